FILE: src/qalu_pkg.sv
// shared types, constants and saturation helper for the q15/q31 alu
package qalu_pkg;

  localparam int DATA_W    = 32;
  localparam int FUNC_W    = 4;
  localparam int PROD_W    = 2 * DATA_W;
  localparam int NUM_W     = 2 * DATA_W - 1;
  localparam int DIV_STEPS = DATA_W;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int Q15_FRAC  = 15;
  localparam int Q31_FRAC  = 31;

  localparam logic [FUNC_W-1:0] FN_Q31_BASE = 4'd6;
  localparam logic [FUNC_W-1:0] FN_LIMIT    = 4'd12;

  localparam logic signed [PROD_W-1:0] Q15_HI = 64'sd32767;
  localparam logic signed [PROD_W-1:0] Q15_LO = -64'sd32768;
  localparam logic signed [PROD_W-1:0] Q31_HI = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] Q31_LO = -64'sd2147483648;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV,
    OP_ABS,
    OP_NEG,
    OP_NONE
  } op_t;

  // clamp a wide signed value to the q15 or q31 range
  function automatic logic [DATA_W-1:0] sat_fmt(input logic signed [PROD_W-1:0] v,
                                                 input logic q15);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    logic [DATA_W-1:0]        r;
    hi = q15 ? Q15_HI : Q31_HI;
    lo = q15 ? Q15_LO : Q31_LO;
    priority if (v > hi) begin
      r = hi[DATA_W-1:0];
    end else if (v < lo) begin
      r = lo[DATA_W-1:0];
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

FILE: src/qalu_div.sv
// pipelined restoring divider, one quotient bit per stage
module qalu_div
  import qalu_pkg::*;
(
  input  logic              clk,
  input  logic [NUM_W-1:0]  num,
  input  logic [DATA_W-1:0] den,
  output logic [DATA_W-1:0] quo,
  output logic              ovf
);

  logic [DATA_W-1:0] rem_r [DIV_STEPS+1];
  logic [DATA_W-1:0] low_r [DIV_STEPS+1];
  logic [DATA_W-1:0] quo_r [DIV_STEPS+1];
  logic [DATA_W-1:0] den_r [DIV_STEPS+1];
  logic              ovf_r [DIV_STEPS+1];

  logic [DATA_W:0]   trial [DIV_STEPS];
  logic              fits  [DIV_STEPS];

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_r[k], low_r[k][DATA_W-1]};
      fits[k]  = trial[k] >= {1'b0, den_r[k]};
    end
  end

  always_ff @(posedge clk) begin
    rem_r[0] <= {1'b0, num[NUM_W-1:DATA_W]};
    low_r[0] <= num[DATA_W-1:0];
    quo_r[0] <= '0;
    den_r[0] <= den;
    // quotient would need more than DATA_W bits
    ovf_r[0] <= {1'b0, num[NUM_W-1:DATA_W]} >= den;
    for (int k = 0; k < DIV_STEPS; k++) begin
      rem_r[k+1] <= fits[k] ? DATA_W'(trial[k] - {1'b0, den_r[k]}) : trial[k][DATA_W-1:0];
      low_r[k+1] <= {low_r[k][DATA_W-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][DATA_W-2:0], fits[k]};
      den_r[k+1] <= den_r[k];
      ovf_r[k+1] <= ovf_r[k];
    end
  end

  assign quo = quo_r[DIV_STEPS];
  assign ovf = ovf_r[DIV_STEPS];

endmodule

FILE: src/saturating_q15_q31_alu_unit.sv
// top level of the saturating q15/q31 fixed-point alu
//
//  channel  ports                                         transfer when
//  input    start, busy, in_func, in_operand_a/b          start && !busy
//  result   out_strobe, out_result                        out_strobe
//
//  one operation accepted every cycle; busy is always low
//  every operation passes the 33-stage divider or its side line
//  operations are delay-matched so results leave in order
//  synchronous reset clears the valid bits only
//  the receiver cannot stall, so nothing in the pipeline holds
module saturating_q15_q31_alu_unit
  import qalu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [DATA_W-1:0] in_operand_a,
  input  logic [DATA_W-1:0] in_operand_b,
  output logic              out_strobe,
  output logic [DATA_W-1:0] out_result
);

  typedef struct packed {
    logic              is_div;
    logic              q15;
    logic              zero;
    logic              a_neg;
    logic              neg_q;
    logic [DATA_W-1:0] res;
  } side_t;

  // input stage
  logic              s0_valid_r;
  logic [FUNC_W-1:0] s0_func_r;
  logic [DATA_W-1:0] s0_a_r;
  logic [DATA_W-1:0] s0_b_r;

  // operand preparation stage
  logic                     s1_valid_r;
  op_t                      s1_op_r;
  logic                     s1_q15_r;
  logic [DATA_W-1:0]        s1_res_r;
  logic signed [PROD_W-1:0] s1_prod_r;
  logic [NUM_W-1:0]         s1_num_r;
  logic [DATA_W-1:0]        s1_den_r;
  logic                     s1_zero_r;
  logic                     s1_a_neg_r;
  logic                     s1_neg_q_r;

  // side line matched to the divider
  logic  dv_r   [DIV_LAT];
  side_t side_r [DIV_LAT];

  logic              out_strobe_r;
  logic [DATA_W-1:0] out_result_r;
  logic              out_q15_r;

  logic              accept;
  logic              q15_c;
  op_t               op_c;
  logic [FUNC_W-1:0] fn_off;
  logic signed [DATA_W-1:0] a_c;
  logic signed [DATA_W-1:0] b_c;
  logic signed [DATA_W:0]   sum_c;
  logic signed [DATA_W:0]   dif_c;
  logic signed [DATA_W:0]   nega_c;
  logic signed [DATA_W:0]   absa_c;
  logic [DATA_W-1:0]        res_c;
  logic [DATA_W-1:0]        mag_a;
  logic [DATA_W-1:0]        mag_b;
  logic [NUM_W-1:0]         num_c;

  logic signed [PROD_W-1:0] rnd_c;
  logic signed [PROD_W-1:0] shf_c;
  logic [DATA_W-1:0]        mul_c;
  side_t                    s2_c;

  logic [DATA_W-1:0] div_q;
  logic              div_ovf;
  side_t             tail;
  logic [DATA_W:0]   hi_mag;
  logic [DATA_W-1:0] fin_c;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    s0_func_r <= in_func;
    s0_a_r    <= in_operand_a;
    s0_b_r    <= in_operand_b;
  end

  // decode, add/sub/abs/neg and divider operand magnitudes
  always_comb begin
    q15_c  = s0_func_r < FN_Q31_BASE;
    fn_off = q15_c ? s0_func_r : s0_func_r - FN_Q31_BASE;
    op_c   = (s0_func_r < FN_LIMIT) ? op_t'(fn_off[2:0]) : OP_NONE;
    a_c    = q15_c ? {{(DATA_W-16){s0_a_r[15]}}, s0_a_r[15:0]} : s0_a_r;
    b_c    = q15_c ? {{(DATA_W-16){s0_b_r[15]}}, s0_b_r[15:0]} : s0_b_r;
    sum_c  = {a_c[DATA_W-1], a_c} + {b_c[DATA_W-1], b_c};
    dif_c  = {a_c[DATA_W-1], a_c} - {b_c[DATA_W-1], b_c};
    nega_c = -{a_c[DATA_W-1], a_c};
    absa_c = a_c[DATA_W-1] ? nega_c : {a_c[DATA_W-1], a_c};
    unique case (op_c)
      OP_ADD:  res_c = sat_fmt(PROD_W'(sum_c), q15_c);
      OP_SUB:  res_c = sat_fmt(PROD_W'(dif_c), q15_c);
      OP_ABS:  res_c = sat_fmt(PROD_W'(absa_c), q15_c);
      OP_NEG:  res_c = sat_fmt(PROD_W'(nega_c), q15_c);
      default: res_c = '0;
    endcase
    mag_a = a_c[DATA_W-1] ? DATA_W'(-a_c) : a_c;
    mag_b = b_c[DATA_W-1] ? DATA_W'(-b_c) : b_c;
    num_c = q15_c ? (NUM_W'(mag_a) << Q15_FRAC) : (NUM_W'(mag_a) << Q31_FRAC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s0_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r    <= op_c;
    s1_q15_r   <= q15_c;
    s1_res_r   <= res_c;
    s1_prod_r  <= a_c * b_c;
    s1_num_r   <= num_c;
    s1_den_r   <= mag_b;
    s1_zero_r  <= b_c == '0;
    s1_a_neg_r <= a_c[DATA_W-1];
    s1_neg_q_r <= a_c[DATA_W-1] ^ b_c[DATA_W-1];
  end

  // multiply rounding: add half an lsb, floor shift, clamp
  always_comb begin
    rnd_c = s1_prod_r + (s1_q15_r ? (PROD_W'(1) <<< (Q15_FRAC - 1))
                                  : (PROD_W'(1) <<< (Q31_FRAC - 1)));
    shf_c = s1_q15_r ? (rnd_c >>> Q15_FRAC) : (rnd_c >>> Q31_FRAC);
    mul_c = sat_fmt(shf_c, s1_q15_r);
    s2_c.is_div = s1_op_r == OP_DIV;
    s2_c.q15    = s1_q15_r;
    s2_c.zero   = s1_zero_r;
    s2_c.a_neg  = s1_a_neg_r;
    s2_c.neg_q  = s1_neg_q_r;
    s2_c.res    = (s1_op_r == OP_MUL) ? mul_c : s1_res_r;
  end

  qalu_div u_div (
    .clk (clk),
    .num (s1_num_r),
    .den (s1_den_r),
    .quo (div_q),
    .ovf (div_ovf)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DIV_LAT; k++) begin
        dv_r[k] <= 1'b0;
      end
    end else begin
      dv_r[0] <= s1_valid_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dv_r[k] <= dv_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    side_r[0] <= s2_c;
    for (int k = 1; k < DIV_LAT; k++) begin
      side_r[k] <= side_r[k-1];
    end
  end

  // quotient sign and saturation
  always_comb begin
    tail   = side_r[DIV_LAT-1];
    hi_mag = tail.q15 ? (DATA_W+1)'(Q15_HI) : (DATA_W+1)'(Q31_HI);
    if (!tail.is_div) begin
      fin_c = tail.res;
    end else if (tail.zero) begin
      fin_c = tail.a_neg ? (tail.q15 ? Q15_LO[DATA_W-1:0] : Q31_LO[DATA_W-1:0])
                         : hi_mag[DATA_W-1:0];
    end else if (tail.neg_q) begin
      fin_c = (div_ovf || {1'b0, div_q} > hi_mag + 1'b1)
            ? (tail.q15 ? Q15_LO[DATA_W-1:0] : Q31_LO[DATA_W-1:0])
            : DATA_W'(-div_q);
    end else begin
      fin_c = (div_ovf || {1'b0, div_q} > hi_mag) ? hi_mag[DATA_W-1:0] : div_q;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= dv_r[DIV_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    out_result_r <= fin_c;
    out_q15_r    <= tail.q15;
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, DIV_LAT + 3))
    else $error("result transfer without a matching input transfer");

  a_q15_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_q15_r) |->
      ((&out_result[DATA_W-1:15]) || !(|out_result[DATA_W-1:15])))
    else $error("q15 result not sign-extended from 16 bits");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_LAT-1] |-> $past(s1_valid_r, DIV_LAT))
    else $error("side line out of step with divider");

endmodule

FILE: dv/tb_saturating_q15_q31_alu_unit.sv
// self-checking testbench for the saturating q15/q31 fixed-point alu
module tb_saturating_q15_q31_alu_unit;
  import qalu_pkg::*;

  localparam int LATENCY     = 36;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_RANDOM    = 800;
  localparam logic [FUNC_W-1:0] FN_Q15_ADD = 4'd0;
  localparam logic [FUNC_W-1:0] FN_Q15_SUB = 4'd1;
  localparam logic [FUNC_W-1:0] FN_Q15_MUL = 4'd2;
  localparam logic [FUNC_W-1:0] FN_Q15_DIV = 4'd3;
  localparam logic [FUNC_W-1:0] FN_Q15_ABS = 4'd4;
  localparam logic [FUNC_W-1:0] FN_Q15_NEG = 4'd5;
  localparam logic [FUNC_W-1:0] FN_Q31_ADD = 4'd6;
  localparam logic [FUNC_W-1:0] FN_Q31_SUB = 4'd7;
  localparam logic [FUNC_W-1:0] FN_Q31_MUL = 4'd8;
  localparam logic [FUNC_W-1:0] FN_Q31_DIV = 4'd9;
  localparam logic [FUNC_W-1:0] FN_Q31_ABS = 4'd10;
  localparam logic [FUNC_W-1:0] FN_Q31_NEG = 4'd11;
  localparam logic [FUNC_W-1:0] FN_UNUSED  = 4'd15;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    bit                typed;
    logic [DATA_W-1:0] res;
  } stim_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [FUNC_W-1:0] in_func;
  logic [DATA_W-1:0] in_operand_a;
  logic [DATA_W-1:0] in_operand_b;
  logic              out_strobe;
  logic [DATA_W-1:0] out_result;

  logic [DATA_W-1:0] pending_results[$];
  int                errors;
  int                cycles;
  int                sender_idle_pct;
  stim_t             directed[$];

  saturating_q15_q31_alu_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic signed [63:0] clamp_fmt(input logic signed [63:0] v, input bit q15);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = q15 ? 64'sd32767 : 64'sd2147483647;
    lo = q15 ? -64'sd32768 : -64'sd2147483648;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // saturated result of one operation
  function automatic logic [DATA_W-1:0] alu_result(input logic [FUNC_W-1:0] func,
                                                   input logic [DATA_W-1:0] a_in,
                                                   input logic [DATA_W-1:0] b_in);
    bit                 q15;
    int unsigned        frac;
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    logic signed [63:0] r;
    logic signed [127:0] wide;
    op_t                op;
    if (func >= FN_LIMIT) return '0;
    q15  = func < FN_Q31_BASE;
    op   = op_t'(q15 ? func : func - FN_Q31_BASE);
    frac = q15 ? 15 : 31;
    a    = q15 ? 64'(signed'(a_in[15:0])) : 64'(signed'(a_in));
    b    = q15 ? 64'(signed'(b_in[15:0])) : 64'(signed'(b_in));
    hi   = q15 ? 64'sd32767 : 64'sd2147483647;
    lo   = q15 ? -64'sd32768 : -64'sd2147483648;
    case (op)
      OP_ADD: r = clamp_fmt(a + b, q15);
      OP_SUB: r = clamp_fmt(a - b, q15);
      OP_MUL: r = clamp_fmt((a * b + (64'sd1 <<< (frac - 1))) >>> frac, q15);
      OP_DIV: begin
        if (b == 0) r = (a >= 0) ? hi : lo;
        else begin
          // quotient truncates toward zero
          wide = (128'(a) <<< frac) / 128'(b);
          if (wide > 128'(hi)) r = hi;
          else if (wide < 128'(lo)) r = lo;
          else r = wide[63:0];
        end
      end
      OP_ABS: r = (a == lo) ? hi : ((a < 0) ? -a : a);
      default: r = (a == lo) ? hi : -a;
    endcase
    return r[DATA_W-1:0];
  endfunction

  function automatic logic [DATA_W-1:0] rand_operand();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'(signed'(16'($urandom)));
      3: return $urandom_range(0, 3);
      4: return 32'h0000_8000 | ($urandom & 32'hffff_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic stim_t mk(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] a,
                               input logic [DATA_W-1:0] b, input bit typed,
                               input logic [DATA_W-1:0] res);
    stim_t s;
    s.func = f; s.a = a; s.b = b; s.typed = typed; s.res = res;
    return s;
  endfunction

  task automatic send(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] a,
                      input logic [DATA_W-1:0] b, input logic [DATA_W-1:0] res);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start        <= 1'b1;
    in_func      <= f;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(res);
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_result);
        errors++;
      end else begin
        if (out_result !== pending_results[0]) begin
          $display("%0t result mismatch: expected %h, actual %h",
                   $time, pending_results[0], out_result);
          errors++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    stim_t            s;
    logic [FUNC_W-1:0] f;
    errors = 0;
    cycles = 0;
    sender_idle_pct = 15;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = '0;
    in_operand_a = '0;
    in_operand_b = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    directed.push_back(mk(FN_Q15_ADD, 32'h0000_7fff, 32'h0000_7fff, 1, 32'h0000_7fff));
    directed.push_back(mk(FN_Q15_ADD, 32'h0000_8000, 32'h0000_8000, 1, 32'hffff_8000));
    directed.push_back(mk(FN_Q15_SUB, 32'h0000_8000, 32'h0000_0001, 1, 32'hffff_8000));
    directed.push_back(mk(FN_Q15_MUL, 32'h0000_8000, 32'h0000_8000, 1, 32'h0000_7fff));
    directed.push_back(mk(FN_Q15_MUL, 32'hffff_1234, 32'h0000_4000, 0, 0));
    directed.push_back(mk(FN_Q15_DIV, 32'h0000_1000, 32'h0000_0000, 1, 32'h0000_7fff));
    directed.push_back(mk(FN_Q15_DIV, 32'h0000_8000, 32'h0000_0000, 1, 32'hffff_8000));
    directed.push_back(mk(FN_Q15_DIV, 32'h0000_c000, 32'h0000_7000, 0, 0));
    directed.push_back(mk(FN_Q15_ABS, 32'h0000_8000, 32'h0, 1, 32'h0000_7fff));
    directed.push_back(mk(FN_Q15_NEG, 32'h0000_8000, 32'h0, 1, 32'h0000_7fff));
    directed.push_back(mk(FN_Q15_NEG, 32'h0000_0005, 32'h0, 1, 32'hffff_fffb));
    directed.push_back(mk(FN_Q31_ADD, 32'h7fff_ffff, 32'h7fff_ffff, 1, 32'h7fff_ffff));
    directed.push_back(mk(FN_Q31_SUB, 32'h8000_0000, 32'h7fff_ffff, 1, 32'h8000_0000));
    directed.push_back(mk(FN_Q31_MUL, 32'h8000_0000, 32'h8000_0000, 1, 32'h7fff_ffff));
    directed.push_back(mk(FN_Q31_MUL, 32'h8765_4321, 32'h1234_5678, 0, 0));
    directed.push_back(mk(FN_Q31_DIV, 32'h0000_0000, 32'h0000_0000, 1, 32'h7fff_ffff));
    directed.push_back(mk(FN_Q31_DIV, 32'hffff_ffff, 32'h0000_0000, 1, 32'h8000_0000));
    directed.push_back(mk(FN_Q31_DIV, 32'hc000_0000, 32'h7000_0001, 0, 0));
    directed.push_back(mk(FN_Q31_ABS, 32'h8000_0000, 32'h0, 1, 32'h7fff_ffff));
    directed.push_back(mk(FN_Q31_NEG, 32'h8000_0000, 32'h0, 1, 32'h7fff_ffff));
    directed.push_back(mk(FN_Q31_NEG, 32'h7fff_ffff, 32'h0, 1, 32'h8000_0001));
    directed.push_back(mk(FN_LIMIT, 32'hffff_ffff, 32'hffff_ffff, 1, 32'h0));
    directed.push_back(mk(FN_UNUSED, 32'h1234_5678, 32'h9abc_def0, 1, 32'h0));

    foreach (directed[i]) begin
      s = directed[i];
      send(s.func, s.a, s.b, s.typed ? s.res : alu_result(s.func, s.a, s.b));
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) sender_idle_pct = 85;
      if (n == 2 * N_RANDOM / 3) sender_idle_pct = 0;
      if (n == N_RANDOM / 2) begin
        // hold off until the pipeline has drained
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      // mostly valid codes, some unused ones
      f = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(12, 15)) : 4'($urandom_range(0, 11));
      s.a = rand_operand();
      s.b = rand_operand();
      send(f, s.a, s.b, alu_result(f, s.a, s.b));
    end
    start <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
